### rtl/assert_macros.svh
// Assertion macros used by the checker.
// Depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/plr_pkg.sv
// Package for the profile linear resampler: types, codes, constants.
// Depends on nothing.
package plr_pkg;

	localparam int unsigned DEF_MAX_POINTS = 256;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NEGATIVE  = 3'd1,
		ST_ORDER     = 3'd2,
		ST_FULL      = 3'd3,
		ST_NO_POINTS = 3'd4
	} status_t;

	// one queued transaction from front to back
	typedef struct packed {
		logic        op;
		logic        first_point;
		logic [31:0] point_position;
		logic [31:0] point_area;
		logic [31:0] point_discharge;
		logic [31:0] point_concentration;
		logic [31:0] node_position;
		logic        last_node;
	} item_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_LOAD_RD,
		B_LOAD_CHK,
		B_Q_RD0,
		B_Q_RD0W,
		B_Q_WALK,
		B_Q_WALKW,
		B_Q_RDL,
		B_Q_RDK,
		B_Q_RDKW,
		B_Q_DIV,
		B_Q_BLEND,
		B_Q_SOL,
		B_EMIT
	} bstate_t;

endpackage

### rtl/plr_front.sv
// Front part: accepts command transactions and holds them in a two-entry queue.
// Depends on plr_pkg.
module plr_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  plr_pkg::item_t  in_item,
	output logic            q_valid,
	output plr_pkg::item_t  q_item,
	input  logic            q_pop,
	input  logic            hold
);
	import plr_pkg::*;

	item_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	// the back end stalls the source while an item is in flight
	assign busy    = (cnt_q != 2'd0) || hold;
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

### rtl/plr_div.sv
// Restoring divider: floor(w * 2^32 / d) with w < d, one quotient bit a cycle.
// Depends on nothing.
module plr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [31:0] w,
	input  logic [31:0] d,
	output logic        done,
	output logic [31:0] quot
);
	logic [32:0] rem_q;
	logic [31:0] d_q, quot_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic [33:0] sh;
	logic [33:0] diff;

	assign sh   = {rem_q, 1'b0};
	assign diff = sh - {2'b0, d_q};
	assign quot = quot_q;
	assign done = run_q && (cnt_q == 6'd0);

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= {1'b0, w};
			d_q    <= d;
			quot_q <= '0;
		end else if (run_q && cnt_q != 6'd0) begin
			if (!diff[33]) begin
				rem_q  <= diff[32:0];
				quot_q <= {quot_q[30:0], 1'b1};
			end else begin
				rem_q  <= sh[32:0];
				quot_q <= {quot_q[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			run_q <= 1'b1;
			cnt_q <= 6'd32;
		end else if (run_q) begin
			if (cnt_q == 6'd0) run_q <= 1'b0;
			else cnt_q <= cnt_q - 6'd1;
		end
	end
endmodule

### rtl/plr_back.sv
// Back part: profile table, cursor walk, interpolation and solute product.
// Depends on plr_pkg and plr_div.
module plr_back #(
	parameter int unsigned MAX_POINTS = plr_pkg::DEF_MAX_POINTS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  plr_pkg::item_t  q_item,
	output logic            q_pop,
	output logic            active,
	output logic            done,
	output logic [2:0]      status,
	output logic [31:0]     node_area,
	output logic [31:0]     node_discharge,
	output logic [31:0]     node_solute
);
	import plr_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_POINTS);

	logic [31:0] mpos [MAX_POINTS];
	logic [31:0] marea [MAX_POINTS];
	logic [31:0] mdis [MAX_POINTS];
	logic [31:0] mconc [MAX_POINTS];

	bstate_t     st_q, st_n;
	item_t       it_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] cur_q, j_q, raddr;
	logic        re, we;
	logic [31:0] rpos_q, rarea_q, rdis_q, rconc_q;
	logic [31:0] x0_q, xj_q, aj_q, qj_q, cj_q;
	logic [2:0]  stat_q;
	logic signed [31:0] a_q, q_q, c_q, s_q;
	logic        go;
	logic        ddone;
	logic [31:0] f;
	logic        oflag_q;
	logic        ofl;
	logic        ld_ok;
	logic [AW-1:0] last;
	logic signed [63:0] prod;
	logic signed [63:0] sfl;

	assign last = AW'(cnt_q - CW'(1));

	always_ff @(posedge clk) begin
		if (we) begin
			mpos[cnt_q[AW-1:0]]  <= it_q.point_position;
			marea[cnt_q[AW-1:0]] <= it_q.point_area;
			mdis[cnt_q[AW-1:0]]  <= it_q.point_discharge;
			mconc[cnt_q[AW-1:0]] <= it_q.point_concentration;
		end
		if (re) begin
			rpos_q  <= mpos[raddr];
			rarea_q <= marea[raddr];
			rdis_q  <= mdis[raddr];
			rconc_q <= mconc[raddr];
		end
	end

	plr_div u_div (
		.clk(clk), .arst_n(arst_n), .go(go),
		.w(xj_q - it_q.node_position), .d(xj_q - rpos_q),
		.done(ddone), .quot(f)
	);

	// vj + floor((vk - vj) * f / 2^32); arithmetic shift floors
	function automatic logic signed [31:0] blend(input logic [31:0] vj, input logic [31:0] vk,
			input logic [31:0] fr);
		logic signed [32:0] df;
		logic signed [65:0] m;
		df = $signed({vk[31], vk}) - $signed({vj[31], vj});
		m  = df * $signed({1'b0, fr});
		return 32'($signed({vj[31], vj}) + 33'(m >>> 32));
	endfunction

	assign prod = a_q * c_q;
	assign sfl  = prod >>> 16;

	// in B_Q_RDK the last point's position sits in rpos_q
	assign ofl   = (it_q.node_position >= rpos_q);
	assign ld_ok = !(it_q.point_area[31] || it_q.point_concentration[31])
		&& !(cnt_q != '0 && it_q.point_position < rpos_q) && (cnt_q < MAXC);

	always_comb begin
		st_n  = st_q;
		re    = 1'b0;
		raddr = j_q;
		go    = 1'b0;
		case (st_q)
			B_IDLE: if (q_valid) st_n = q_item.op ? B_Q_RD0 : B_LOAD_RD;
			B_LOAD_RD: begin
				re    = 1'b1;
				raddr = last;
				st_n  = B_LOAD_CHK;
			end
			B_LOAD_CHK: st_n = B_EMIT;
			B_Q_RD0: begin
				if (cnt_q == '0) st_n = B_EMIT;
				else begin
					re    = 1'b1;
					raddr = '0;
					st_n  = B_Q_RD0W;
				end
			end
			B_Q_RD0W: begin
				re   = 1'b1;
				st_n = B_Q_WALKW;
			end
			B_Q_WALK: begin
				re   = 1'b1;
				st_n = B_Q_WALKW;
			end
			B_Q_WALKW: begin
				if (it_q.node_position > rpos_q && j_q < last) st_n = B_Q_WALK;
				else st_n = B_Q_RDL;
			end
			B_Q_RDL: begin
				re    = 1'b1;
				raddr = last;
				st_n  = B_Q_RDK;
			end
			B_Q_RDK: begin
				re    = 1'b1;
				// low clamp wins over high clamp
				if (it_q.node_position <= x0_q) raddr = '0;
				else if (ofl) raddr = last;
				else raddr = (j_q == '0) ? '0 : j_q - AW'(1);
				st_n  = B_Q_RDKW;
			end
			B_Q_RDKW: begin
				if (oflag_q || it_q.node_position <= x0_q
						|| (xj_q - it_q.node_position) >= (xj_q - rpos_q))
					st_n = B_Q_SOL;
				else begin
					go   = 1'b1;
					st_n = B_Q_DIV;
				end
			end
			B_Q_DIV: if (ddone) st_n = B_Q_BLEND;
			B_Q_BLEND: st_n = B_Q_SOL;
			B_Q_SOL: st_n = B_EMIT;
			B_EMIT: st_n = B_IDLE;
			default: st_n = B_IDLE;
		endcase
	end

	assign q_pop = (st_q == B_IDLE) && q_valid;
	assign active = (st_q != B_IDLE);
	assign we    = (st_q == B_LOAD_CHK) && ld_ok;
	assign done  = (st_q == B_EMIT);
	assign status = stat_q;
	assign node_area      = a_q;
	assign node_discharge = q_q;
	assign node_solute    = s_q;

	always_ff @(posedge clk) begin
		case (st_q)
			B_IDLE: if (q_valid) begin
				it_q <= q_item;
				a_q  <= '0;
				q_q  <= '0;
				s_q  <= '0;
				c_q  <= '0;
			end
			B_Q_RD0W: x0_q <= rpos_q;
			B_Q_WALKW: begin
				xj_q <= rpos_q;
				aj_q <= rarea_q;
				qj_q <= rdis_q;
				cj_q <= rconc_q;
			end
			B_Q_RDK: oflag_q <= ofl;
			B_Q_RDKW: begin
				// clamp or weight of one: take the selected point as is
				if (it_q.node_position <= x0_q && !oflag_q) begin
					a_q <= '0; // refreshed below from point 0 when needed
				end
				if (oflag_q || (xj_q - it_q.node_position) >= (xj_q - rpos_q)
						|| it_q.node_position <= x0_q) begin
					a_q <= rarea_q;
					q_q <= rdis_q;
					c_q <= rconc_q;
				end
			end
			B_Q_BLEND: begin
				a_q <= blend(aj_q, rarea_q, f);
				q_q <= blend(qj_q, rdis_q, f);
				c_q <= blend(cj_q, rconc_q, f);
			end
			B_Q_SOL: begin
				if (sfl > 64'sd2147483647) s_q <= 32'h7FFF_FFFF;
				else if (sfl < -64'sd2147483648) s_q <= 32'h8000_0000;
				else s_q <= sfl[31:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= B_IDLE;
			cnt_q  <= '0;
			cur_q  <= '0;
			j_q    <= '0;
			stat_q <= ST_OK;
		end else begin
			st_q <= st_n;
			case (st_q)
				B_IDLE: if (q_valid) begin
					stat_q <= ST_OK;
					if (!q_item.op && q_item.first_point) begin
						cnt_q <= '0;
						cur_q <= '0;
					end
				end
				B_LOAD_CHK: begin
					if (it_q.point_area[31] || it_q.point_concentration[31])
						stat_q <= ST_NEGATIVE;
					else if (cnt_q != '0 && it_q.point_position < rpos_q)
						stat_q <= ST_ORDER;
					else if (cnt_q >= MAXC)
						stat_q <= ST_FULL;
					else
						cnt_q <= cnt_q + CW'(1);
				end
				B_Q_RD0: begin
					if (cnt_q == '0) stat_q <= ST_NO_POINTS;
					else j_q <= (CW'(cur_q) > CW'(last)) ? last : cur_q;
				end
				B_Q_WALKW: begin
					if (it_q.node_position > rpos_q && j_q < last) j_q <= j_q + AW'(1);
					else cur_q <= j_q;
				end
				B_EMIT: if (it_q.op && it_q.last_node && stat_q == ST_OK) cur_q <= '0;
				default: ;
			endcase
		end
	end
endmodule

### rtl/profile_linear_resampler_top.sv
// Profile linear resampler: loads profile points, answers mesh node queries.
// Channels: one command port, start/busy. A transaction is taken at a rising
// edge with start high and busy low; op selects load (0) or query (1).
// Each transaction yields one result, shown for one cycle with done high.
// A load reads the last stored point, checks the new one and then shows its
// result; a query on an empty table goes straight to its result. An
// interpolated query waits for the cursor walk over the table, one step at a
// time through the single table read port, and for the one-bit-a-cycle
// divider. Clamped or weight-one queries skip the divider but still walk.
// busy stays high from acceptance until the result has been shown, so
// one transaction is in flight at a time and the next one can be taken in the
// cycle after the result.
// Results cannot be held off: the receiver must take them when done is high.
// Reset (arst_n low) empties the table and clears the cursor; table
// memory contents are not cleared, and values of unwritten entries are never used.
// Depends on plr_pkg, plr_front, plr_back, plr_div.
module profile_linear_resampler_top #(
	parameter int unsigned MAX_POINTS = plr_pkg::DEF_MAX_POINTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic        first_point,
	input  logic [31:0] point_position,
	input  logic [31:0] point_area,
	input  logic [31:0] point_discharge,
	input  logic [31:0] point_concentration,
	input  logic [31:0] node_position,
	input  logic        last_node,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] node_area,
	output logic [31:0] node_discharge,
	output logic [31:0] node_solute
);
	import plr_pkg::*;

	item_t in_item, q_item;
	logic  q_valid, q_pop;
	logic  back_active;

	always_comb begin
		in_item.op                  = op;
		in_item.first_point         = first_point;
		in_item.point_position      = point_position;
		in_item.point_area          = point_area;
		in_item.point_discharge     = point_discharge;
		in_item.point_concentration = point_concentration;
		in_item.node_position       = node_position;
		in_item.last_node           = last_node;
	end

	plr_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_item(in_item), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.hold(back_active)
	);

	plr_back #(.MAX_POINTS(MAX_POINTS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item),
		.q_pop(q_pop), .active(back_active), .done(done), .status(status),
		.node_area(node_area), .node_discharge(node_discharge),
		.node_solute(node_solute)
	);
endmodule

### rtl/plr_checker.sv
// Port-level checker for the profile linear resampler, bound to the top.
// Depends on plr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module plr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [2:0]  status,
	input logic [31:0] node_area,
	input logic [31:0] node_discharge,
	input logic [31:0] node_solute
);
	import plr_pkg::*;

	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "no busy after accept")
	`ASSERT_IMPL(a_done_busy, clk, arst_n, done, busy, "result without transaction")
	`ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "result held two cycles")
	`ASSERT_IMPL(a_nopts_zero, clk, arst_n, done && status == ST_NO_POINTS,
		node_area == '0 && node_discharge == '0 && node_solute == '0, "nonzero empty query")
	`ASSERT_IMPL(a_status_range, clk, arst_n, done, status <= ST_NO_POINTS, "bad status")
endmodule

bind profile_linear_resampler_top plr_checker u_plr_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .node_area(node_area), .node_discharge(node_discharge),
	.node_solute(node_solute)
);
